FILE: sv/cppf_pkg.sv
// cppf_pkg: types, widths and register codes for class_probability_product_fusion.
// No dependencies; imported by every module of the block.
`default_nettype none
package cppf_pkg;

    localparam int MAX_CLASSES = 32;
    localparam int SCORE_BITS  = 16;

    localparam int IDX_W    = $clog2(MAX_CLASSES);
    localparam int CNT_W    = $clog2(MAX_CLASSES + 1);
    localparam int SUM_W    = SCORE_BITS + IDX_W;
    localparam int PROD_W   = 2 * SCORE_BITS;
    localparam int PTOT_W   = PROD_W + IDX_W;
    localparam int V_W      = SCORE_BITS + SUM_W + 1;
    localparam int VTOT_W   = V_W + IDX_W;
    localparam int NB_W     = V_W + CNT_W;
    localparam int DIFF_W   = (NB_W > VTOT_W + 1) ? NB_W : VTOT_W + 1;
    localparam int DEN_W    = VTOT_W + CNT_W;
    localparam int Q_W      = 10;
    localparam int NUM_W    = DIFF_W + Q_W;
    localparam int CAND_W   = DEN_W + Q_W;
    localparam int MEM_AW   = IDX_W + 1;
    localparam int LABEL_W  = 8;
    localparam int CFG_W    = 64;
    localparam int CFG_IW   = 3;

    typedef enum logic [CFG_IW-1:0] {
        REG_LABELS_0 = 3'd0,
        REG_LABELS_1 = 3'd1,
        REG_LABELS_2 = 3'd2,
        REG_LABELS_3 = 3'd3,
        REG_CROP_MASK = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [SCORE_BITS-1:0] prob_first;
        logic [SCORE_BITS-1:0] prob_second;
        logic                  last_class;
    } in_item_t;

    typedef struct packed {
        logic               crop_mask;
        logic [Q_W-1:0]     mask_quality;
        logic [LABEL_W-1:0] crop_type;
        logic [Q_W-1:0]     type_quality;
        logic               invalid;
    } out_item_t;

    // one finished pixel, handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0]  sum_first;
        logic [SUM_W-1:0]  sum_second;
        logic [PTOT_W-1:0] product_total;
        logic [PTOT_W-1:0] product_crop_total;
        logic [PROD_W-1:0] best_product;
        logic [IDX_W-1:0]  best_index;
        logic [CNT_W-1:0]  class_count;
        logic              overflow;
        logic              bank;
    } pixel_desc_t;

endpackage
`default_nettype wire

FILE: sv/cppf_front.sv
// cppf_front: accepts class requests, accumulates per-pixel sums, stores scores
// in a two-bank memory and emits a pixel descriptor. Depends on cppf_pkg.
`default_nettype none
module cppf_front
    import cppf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire in_item_t                item,
    input  wire logic [MAX_CLASSES-1:0]  crop_bits,
    output logic                         desc_push,
    output pixel_desc_t                  desc,
    input  wire logic                    rd_en,
    input  wire logic [MEM_AW-1:0]       rd_addr,
    output logic [PROD_W-1:0]            rd_data
);

    logic [PROD_W-1:0] mem [2**MEM_AW];

    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [SUM_W-1:0]  sum1_reg,  sum1_next;
    logic [SUM_W-1:0]  sum2_reg,  sum2_next;
    logic [PTOT_W-1:0] ptot_reg,  ptot_next;
    logic [PTOT_W-1:0] pcrop_reg, pcrop_next;
    logic [PROD_W-1:0] best_reg,  best_next;
    logic [IDX_W-1:0]  bidx_reg,  bidx_next;
    logic              ovf_reg,   ovf_next;
    logic              bank_reg;
    logic              in_range;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rd_data_reg;

    assign in_range = (cnt_reg < CNT_W'(MAX_CLASSES));
    assign prod = PROD_W'(item.prob_first) * PROD_W'(item.prob_second);

    always_comb
    begin
        cnt_next   = cnt_reg;
        sum1_next  = sum1_reg;
        sum2_next  = sum2_reg;
        ptot_next  = ptot_reg;
        pcrop_next = pcrop_reg;
        best_next  = best_reg;
        bidx_next  = bidx_reg;
        ovf_next   = ovf_reg;
        if (in_range)
        begin
            cnt_next  = cnt_reg + 1'b1;
            sum1_next = sum1_reg + SUM_W'(item.prob_first);
            sum2_next = sum2_reg + SUM_W'(item.prob_second);
            ptot_next = ptot_reg + PTOT_W'(prod);
            if (crop_bits[cnt_reg[IDX_W-1:0]])
                pcrop_next = pcrop_reg + PTOT_W'(prod);
            if (prod > best_reg)
            begin
                best_next = prod;
                bidx_next = cnt_reg[IDX_W-1:0];
            end
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    assign desc_push = accept && item.last_class;

    always_comb
    begin
        desc.sum_first          = sum1_next;
        desc.sum_second         = sum2_next;
        desc.product_total      = ptot_next;
        desc.product_crop_total = pcrop_next;
        desc.best_product       = best_next;
        desc.best_index         = bidx_next;
        desc.class_count        = cnt_next;
        desc.overflow           = ovf_next;
        desc.bank               = bank_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            sum1_reg  <= '0;
            sum2_reg  <= '0;
            ptot_reg  <= '0;
            pcrop_reg <= '0;
            best_reg  <= '0;
            bidx_reg  <= '0;
            ovf_reg   <= 1'b0;
            bank_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (item.last_class)
            begin
                cnt_reg   <= '0;
                sum1_reg  <= '0;
                sum2_reg  <= '0;
                ptot_reg  <= '0;
                pcrop_reg <= '0;
                best_reg  <= '0;
                bidx_reg  <= '0;
                ovf_reg   <= 1'b0;
                bank_reg  <= ~bank_reg;
            end
            else
            begin
                cnt_reg   <= cnt_next;
                sum1_reg  <= sum1_next;
                sum2_reg  <= sum2_next;
                ptot_reg  <= ptot_next;
                pcrop_reg <= pcrop_next;
                best_reg  <= best_next;
                bidx_reg  <= bidx_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // score store, bank selects the pixel
    always_ff @(posedge clk)
    begin
        if (accept && in_range)
            mem[{bank_reg, cnt_reg[IDX_W-1:0]}] <= {item.prob_first, item.prob_second};
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: sv/cppf_desc_fifo.sv
// cppf_desc_fifo: two-entry queue of pixel descriptors between front and back.
// Depends on cppf_pkg.
`default_nettype none
module cppf_desc_fifo
    import cppf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire pixel_desc_t wr_data,
    input  wire logic        rd_en,
    output pixel_desc_t      rd_data,
    output logic             full,
    output logic             empty
);

    pixel_desc_t entry_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = entry_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule
`default_nettype wire

FILE: sv/cppf_back.sv
// cppf_back: per-pixel evaluation: fallback rescan, quality numerators, shared
// restoring divider and the result register. Depends on cppf_pkg.
`default_nettype none
module cppf_back
    import cppf_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  wire pixel_desc_t                   q_data,
    output logic                               q_pop,
    input  wire logic [MAX_CLASSES-1:0]        crop_bits,
    input  wire logic [MAX_CLASSES*LABEL_W-1:0] labels,
    output logic                               rd_en,
    output logic [MEM_AW-1:0]                  rd_addr,
    input  wire logic [PROD_W-1:0]             rd_data,
    output out_item_t                          result,
    output logic                               empty,
    input  wire logic                          pop
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_PREP1 = 7'b0000100,
        ST_PREP2 = 7'b0001000,
        ST_PREP3 = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t             state_reg;
    pixel_desc_t        d_reg;
    logic [VTOT_W-1:0]  total_reg, crop_tot_reg;
    logic [V_W-1:0]     best_reg;
    logic [IDX_W-1:0]   win_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic               r_vld_reg, p_vld_reg;
    logic [IDX_W-1:0]   r_idx_reg, p_idx_reg;
    logic [V_W-2:0]     pa_reg, pb_reg;
    logic               crop_reg, inv_reg;
    logic [LABEL_W-1:0] type_reg;
    logic [DIFF_W-1:0]  mq_diff_reg, tq_diff_reg;
    logic [NB_W-1:0]    nb_reg;
    logic [DEN_W-1:0]   den_reg, div_den_reg;
    logic [NUM_W-1:0]   tq_num_reg, rem_reg;
    logic [Q_W-1:0]     q_reg, mq_reg, tq_reg;
    logic [3:0]         k_reg;
    logic               phase_reg;
    logic               out_vld_reg;
    out_item_t          out_reg;

    logic               inv_now;
    logic [VTOT_W-1:0]  group;
    logic [DIFF_W-1:0]  twice;
    logic [V_W-1:0]     v_sum;
    logic [CAND_W-1:0]  cand;
    logic               ge;
    logic [Q_W-1:0]     q_next;

    assign inv_now = (q_data.sum_first == '0) || (q_data.sum_second == '0)
                  || (q_data.class_count < CNT_W'(2)) || q_data.overflow;
    assign group = crop_bits[win_reg] ? crop_tot_reg : total_reg - crop_tot_reg;
    assign twice = DIFF_W'(group) << 1;
    assign v_sum = V_W'(pa_reg) + V_W'(pb_reg);
    assign cand  = CAND_W'(div_den_reg) << k_reg;
    assign ge    = CAND_W'(rem_reg) >= cand;
    assign q_next = q_reg | (ge ? (Q_W'(1) << k_reg) : '0);

    assign rd_en   = (state_reg == ST_SCAN) && (rd_idx_reg < d_reg.class_count);
    assign rd_addr = {d_reg.bank, rd_idx_reg[IDX_W-1:0]};
    assign q_pop   = (state_reg == ST_DONE) && !out_vld_reg;
    assign result  = out_reg;
    assign empty   = !out_vld_reg;

    // datapath
    always_ff @(posedge clk)
    begin
        pa_reg    <= (V_W-1)'(rd_data[PROD_W-1:SCORE_BITS]) * (V_W-1)'(d_reg.sum_second);
        pb_reg    <= (V_W-1)'(rd_data[SCORE_BITS-1:0]) * (V_W-1)'(d_reg.sum_first);
        p_idx_reg <= r_idx_reg;
        r_idx_reg <= rd_idx_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                // a zero product total also means zero crop total, best and index
                d_reg        <= q_data;
                total_reg    <= VTOT_W'(q_data.product_total);
                crop_tot_reg <= VTOT_W'(q_data.product_crop_total);
                best_reg     <= V_W'(q_data.best_product);
                win_reg      <= q_data.best_index;
                inv_reg      <= inv_now;
                crop_reg     <= 1'b0;
                type_reg     <= '0;
                mq_reg       <= '0;
                tq_reg       <= '0;
            end
            ST_SCAN:
            begin
                if (p_vld_reg)
                begin
                    total_reg <= total_reg + VTOT_W'(v_sum);
                    if (crop_bits[p_idx_reg])
                        crop_tot_reg <= crop_tot_reg + VTOT_W'(v_sum);
                    if (v_sum > best_reg)
                    begin
                        best_reg <= v_sum;
                        win_reg  <= p_idx_reg;
                    end
                end
            end
            ST_PREP1:
            begin
                crop_reg    <= crop_bits[win_reg];
                type_reg    <= labels[win_reg*LABEL_W +: LABEL_W];
                mq_diff_reg <= (twice > DIFF_W'(total_reg)) ? twice - DIFF_W'(total_reg) : '0;
                nb_reg      <= NB_W'(d_reg.class_count) * NB_W'(best_reg);
                den_reg     <= DEN_W'(total_reg) * DEN_W'(d_reg.class_count - 1'b1);
            end
            ST_PREP2:
            begin
                tq_diff_reg <= (DIFF_W'(nb_reg) > DIFF_W'(total_reg))
                             ? DIFF_W'(nb_reg) - DIFF_W'(total_reg) : '0;
                rem_reg     <= NUM_W'(mq_diff_reg) * NUM_W'(1000);
                div_den_reg <= DEN_W'(total_reg);
                q_reg       <= '0;
                k_reg       <= 4'(Q_W - 1);
                phase_reg   <= 1'b0;
            end
            ST_PREP3:
            begin
                tq_num_reg <= NUM_W'(tq_diff_reg) * NUM_W'(1000);
            end
            ST_DIV:
            begin
                if (k_reg == '0 && !phase_reg)
                begin
                    mq_reg      <= q_next;
                    rem_reg     <= tq_num_reg;
                    div_den_reg <= den_reg;
                    q_reg       <= '0;
                    k_reg       <= 4'(Q_W - 1);
                    phase_reg   <= 1'b1;
                end
                else
                begin
                    if (ge)
                        rem_reg <= rem_reg - NUM_W'(cand);
                    q_reg <= q_next;
                    k_reg <= k_reg - 1'b1;
                    if (k_reg == '0)
                        tq_reg <= q_next;
                end
            end
            ST_DONE:
            begin
                if (!out_vld_reg)
                begin
                    out_reg.crop_mask    <= crop_reg;
                    out_reg.mask_quality <= mq_reg;
                    out_reg.crop_type    <= crop_reg ? type_reg : '0;
                    out_reg.type_quality <= crop_reg ? tq_reg : '0;
                    out_reg.invalid      <= inv_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_idx_reg  <= '0;
            r_vld_reg   <= 1'b0;
            p_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            r_vld_reg <= rd_en;
            p_vld_reg <= r_vld_reg;
            if (rd_en)
                rd_idx_reg <= rd_idx_reg + 1'b1;
            if (pop && out_vld_reg)
                out_vld_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    rd_idx_reg <= '0;
                    if (!q_empty)
                    begin
                        if (inv_now)
                            state_reg <= ST_DONE;
                        else if (q_data.product_total == '0)
                            state_reg <= ST_SCAN;
                        else
                            state_reg <= ST_PREP1;
                    end
                end
                ST_SCAN:
                begin
                    if (!rd_en && !r_vld_reg && !p_vld_reg)
                        state_reg <= ST_PREP1;
                end
                ST_PREP1: state_reg <= ST_PREP2;
                ST_PREP2: state_reg <= ST_PREP3;
                ST_PREP3: state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (k_reg == '0 && (phase_reg || !crop_reg))
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_vld_reg)
                    begin
                        out_vld_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: sv/class_probability_product_fusion.sv
// class_probability_product_fusion: top level, configuration registers and
// wiring of cppf_front, cppf_desc_fifo and cppf_back. Depends on cppf_pkg.
//
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------------
//  input    | push / full       | item   : prob_first, prob_second, last_class
//  result   | pop / empty       | result : crop_mask, mask_quality, crop_type,
//           |                   |          type_quality, invalid
//  config   | cfg_we            | cfg_index, cfg_data (64 bits)
//
// Class requests are taken one per cycle; the front stalls (full) only when
// two finished pixels are still waiting for the back, since each holds a bank
// of the score memory. The back takes a valid pixel through idle, three prep,
// two 10-step divisions and done; it skips the second division when the winner
// is not a crop class, sends an invalid pixel from idle straight to done, and
// runs the fallback rescan before the prep when all products are zero.
// Reset clears all control state and the configuration registers; no clearing
// pass is needed. An unpopped result stalls the back and so can block the front.
`default_nettype none
module class_probability_product_fusion
    import cppf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire in_item_t          item,
    input  wire logic              pop,
    output logic                   empty,
    output out_item_t              result,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    logic [MAX_CLASSES*LABEL_W-1:0] labels_reg;
    logic [MAX_CLASSES-1:0]         crop_mask_reg;

    logic              accept;
    logic              desc_push, q_pop, q_empty;
    pixel_desc_t       desc, q_data;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    logic [PROD_W-1:0] rd_data;

    // register writes; indexes off the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            labels_reg    <= '0;
            crop_mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LABELS_0:  labels_reg[0*CFG_W +: CFG_W] <= cfg_data;
                REG_LABELS_1:  labels_reg[1*CFG_W +: CFG_W] <= cfg_data;
                REG_LABELS_2:  labels_reg[2*CFG_W +: CFG_W] <= cfg_data;
                REG_LABELS_3:  labels_reg[3*CFG_W +: CFG_W] <= cfg_data;
                REG_CROP_MASK: crop_mask_reg <= cfg_data[MAX_CLASSES-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // a request is taken whenever the descriptor queue has room
    assign accept = push && !full;

    cppf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .crop_bits (crop_mask_reg),
        .desc_push (desc_push),
        .desc      (desc),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    cppf_desc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_push),
        .wr_data (desc),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    cppf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .crop_bits (crop_mask_reg),
        .labels    (labels_reg),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
`default_nettype wire
